// ===== hw/rtl/psrm_pkg.sv =====
// Shared constants and codes for the process status record matcher.
`default_nettype none

package psrm_pkg;

    localparam int NUMBER_WIDTH_DEFAULT = 64;
    localparam int CFG_DATA_WIDTH       = 64;
    localparam int CFG_INDEX_WIDTH      = 2;
    localparam int ID_WIDTH             = 32;

    // Configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CHILD_ID    = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PARENT_ID   = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_TICKS = 2'd2;

    // Verdict codes
    localparam logic [1:0] VERDICT_MATCH    = 2'd0;
    localparam logic [1:0] VERDICT_MISMATCH = 2'd1;
    localparam logic [1:0] VERDICT_NUL      = 2'd2;

    // Characters
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_OPEN  = 8'h28;
    localparam logic [7:0] CHAR_CLOSE = 8'h29;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // Fields five to twenty-one are skipped before the start tick field
    localparam int FIRST_SKIP_FIELD  = 5;
    localparam int TICKS_FIELD       = 22;
    localparam int SKIP_COUNT_WIDTH  = 5;
    localparam logic [SKIP_COUNT_WIDTH-1:0] SKIP_LAST =
        SKIP_COUNT_WIDTH'(TICKS_FIELD - FIRST_SKIP_FIELD - 1);

endpackage : psrm_pkg

`default_nettype wire

// ===== hw/rtl/psrm_decimal.sv =====
// Decimal digit accumulator: value * 10 + digit with overflow detection.
`default_nettype none

module psrm_decimal
    import psrm_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEFAULT
)
(
    input  wire logic [7:0]              text_byte,
    input  wire logic [NUMBER_WIDTH-1:0] value,
    input  wire logic                    overflow,
    output logic                         is_digit,
    output logic [NUMBER_WIDTH-1:0]      value_next,
    output logic                         overflow_next
);

    localparam int SUM_WIDTH = NUMBER_WIDTH + 4;

    logic [3:0]           digit;
    logic [SUM_WIDTH-1:0] value_ext;
    logic [SUM_WIDTH-1:0] sum;
    logic                 fits;

    assign is_digit  = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
    assign digit     = 4'(text_byte - CHAR_ZERO);
    assign value_ext = SUM_WIDTH'(value);
    // times ten as two shifts and an add
    assign sum       = (value_ext << 3) + (value_ext << 1) + SUM_WIDTH'(digit);
    assign fits      = (sum[SUM_WIDTH-1:NUMBER_WIDTH] == '0);

    always_comb
    begin
        value_next    = value;
        overflow_next = overflow;
        if (!overflow)
        begin
            if (fits)
            begin
                value_next = sum[NUMBER_WIDTH-1:0];
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end
    end

endmodule : psrm_decimal

`default_nettype wire

// ===== hw/rtl/process_stat_record_matcher.sv =====
// Top level of the process status record matcher.
//
//  Channel  Direction  Signals                       Content
//  -------  ---------  ----------------------------  ---------------------------------
//  s_*      in         s_tvalid s_tready s_tdata     text_byte in tdata[7:0],
//                      s_tlast                       last_byte on tlast
//  m_*      out        m_tvalid m_tready m_tdata     verdict in tdata[1:0], rest zero
//  cfg_*    in         cfg_we cfg_index cfg_data     0 child id, 1 parent id,
//                                                    2 start ticks
//
// One byte per cycle while s_tready is high: each accepted byte updates the parse state
// through the digit accumulator and one compare against a register.
// A verdict lands in the output register in the cycle after the last byte is accepted.
// While a verdict is held and m_tready is low, s_tready is low for every byte,
// so the parse state holds; s_tready follows m_tready whenever a verdict waits.
// Reset clears the parse state, the configuration registers and the output
// valid; the parse state also returns to reset after every last byte.
`default_nettype none

module process_stat_record_matcher
    import psrm_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEFAULT
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // slave side
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [7:0]                 s_tdata,   // [7:0] text_byte
    input  wire logic                       s_tlast,   // last_byte
    // master side
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [7:0]                      m_tdata,   // [1:0] verdict, [7:2] zero
    // configuration
    input  wire logic                       cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    typedef enum logic [1:0] {
        P_ID,
        P_OPEN,
        P_BODY,
        P_FAIL
    } prefix_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_SP1,
        T_STATE,
        T_SP2,
        T_PARENT,
        T_SKIP,
        T_TICKS,
        T_DONE
    } tail_t;

    // configuration registers
    logic [ID_WIDTH-1:0]       child_id_reg;
    logic [ID_WIDTH-1:0]       parent_id_reg;
    logic [CFG_DATA_WIDTH-1:0] start_ticks_reg;

    // parse state
    prefix_t                     prefix_reg, prefix_next;
    tail_t                       tail_reg, tail_next;
    logic [NUMBER_WIDTH-1:0]     value_reg, value_next;
    logic                        overflow_reg, overflow_next;
    logic                        digit_seen_reg, digit_seen_next;
    logic [SKIP_COUNT_WIDTH-1:0] skipped_reg, skipped_next;
    logic                        tail_ok_reg, tail_ok_next;
    logic                        nul_reg, nul_next;

    // output register
    logic       out_valid_reg;
    logic [1:0] verdict_reg, verdict_next;

    logic                    accept_in;
    logic [7:0]              b;
    logic                    is_digit;
    logic [NUMBER_WIDTH-1:0] acc_value;
    logic                    acc_overflow;
    logic [CFG_DATA_WIDTH-1:0] value_ext;
    logic                    number_clean;
    logic                    is_space;

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept_in = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {6'b0, verdict_reg};
    assign b         = s_tdata;
    assign is_space  = (b == CHAR_SPACE);

    psrm_decimal #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_decimal (
        .text_byte     (b),
        .value         (value_reg),
        .overflow      (overflow_reg),
        .is_digit      (is_digit),
        .value_next    (acc_value),
        .overflow_next (acc_overflow)
    );

    // a finished decimal is usable when it has digits, did not overflow and ends in a space
    assign value_ext    = CFG_DATA_WIDTH'(value_reg);
    assign number_clean = digit_seen_reg && !overflow_reg && is_space;

    always_comb
    begin
        prefix_next     = prefix_reg;
        tail_next       = tail_reg;
        value_next      = value_reg;
        overflow_next   = overflow_reg;
        digit_seen_next = digit_seen_reg;
        skipped_next    = skipped_reg;
        tail_ok_next    = tail_ok_reg;
        nul_next        = nul_reg || (b == CHAR_NUL);
        verdict_next    = verdict_reg;

        case (prefix_reg)
            P_ID:
            begin
                if (is_digit)
                begin
                    value_next      = acc_value;
                    overflow_next   = acc_overflow;
                    digit_seen_next = 1'b1;
                end
                else if (number_clean && value_ext == CFG_DATA_WIDTH'(child_id_reg))
                begin
                    prefix_next = P_OPEN;
                end
                else
                begin
                    prefix_next = P_FAIL;
                end
            end
            P_OPEN:
            begin
                prefix_next = (b == CHAR_OPEN) ? P_BODY : P_FAIL;
            end
            P_BODY:
            begin
                if (b == CHAR_CLOSE)
                begin
                    // restart tail checks at every close paren
                    tail_next    = T_SP1;
                    tail_ok_next = 1'b0;
                end
                else
                begin
                    case (tail_reg)
                        T_SP1:
                        begin
                            tail_next = is_space ? T_STATE : T_DONE;
                        end
                        T_STATE:
                        begin
                            tail_next = !is_space ? T_SP2 : T_DONE;
                        end
                        T_SP2:
                        begin
                            if (is_space)
                            begin
                                tail_next       = T_PARENT;
                                value_next      = '0;
                                overflow_next   = 1'b0;
                                digit_seen_next = 1'b0;
                            end
                            else
                            begin
                                tail_next = T_DONE;
                            end
                        end
                        T_PARENT:
                        begin
                            if (is_digit)
                            begin
                                value_next      = acc_value;
                                overflow_next   = acc_overflow;
                                digit_seen_next = 1'b1;
                            end
                            else if (number_clean &&
                                     value_ext == CFG_DATA_WIDTH'(parent_id_reg))
                            begin
                                tail_next       = T_SKIP;
                                skipped_next    = '0;
                                digit_seen_next = 1'b0;
                            end
                            else
                            begin
                                tail_next = T_DONE;
                            end
                        end
                        T_SKIP:
                        begin
                            if (!is_space)
                            begin
                                digit_seen_next = 1'b1;
                            end
                            else if (!digit_seen_reg)
                            begin
                                tail_next = T_DONE;
                            end
                            else
                            begin
                                skipped_next    = skipped_reg + 1'b1;
                                digit_seen_next = 1'b0;
                                if (skipped_reg == SKIP_LAST)
                                begin
                                    tail_next     = T_TICKS;
                                    value_next    = '0;
                                    overflow_next = 1'b0;
                                end
                            end
                        end
                        T_TICKS:
                        begin
                            if (is_digit)
                            begin
                                value_next      = acc_value;
                                overflow_next   = acc_overflow;
                                digit_seen_next = 1'b1;
                            end
                            else
                            begin
                                tail_ok_next = number_clean &&
                                               (value_ext == start_ticks_reg);
                                tail_next    = T_DONE;
                            end
                        end
                        default:
                        begin
                            tail_next = tail_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                prefix_next = prefix_reg;
            end
        endcase

        if (s_tlast)
        begin
            // judge the record, then drop all parse state for the next one
            if (nul_next)
            begin
                verdict_next = VERDICT_NUL;
            end
            else if (prefix_next == P_BODY && tail_ok_next)
            begin
                verdict_next = VERDICT_MATCH;
            end
            else
            begin
                verdict_next = VERDICT_MISMATCH;
            end
            prefix_next     = P_ID;
            tail_next       = T_IDLE;
            value_next      = '0;
            overflow_next   = 1'b0;
            digit_seen_next = 1'b0;
            skipped_next    = '0;
            tail_ok_next    = 1'b0;
            nul_next        = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            child_id_reg    <= '0;
            parent_id_reg   <= '0;
            start_ticks_reg <= '0;
            prefix_reg      <= P_ID;
            tail_reg        <= T_IDLE;
            value_reg       <= '0;
            overflow_reg    <= 1'b0;
            digit_seen_reg  <= 1'b0;
            skipped_reg     <= '0;
            tail_ok_reg     <= 1'b0;
            nul_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            verdict_reg     <= VERDICT_MATCH;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CHILD_ID:    child_id_reg    <= cfg_data[ID_WIDTH-1:0];
                    REG_PARENT_ID:   parent_id_reg   <= cfg_data[ID_WIDTH-1:0];
                    REG_START_TICKS: start_ticks_reg <= cfg_data;
                    default:         ;
                endcase
            end

            if (accept_in)
            begin
                prefix_reg     <= prefix_next;
                tail_reg       <= tail_next;
                value_reg      <= value_next;
                overflow_reg   <= overflow_next;
                digit_seen_reg <= digit_seen_next;
                skipped_reg    <= skipped_next;
                tail_ok_reg    <= tail_ok_next;
                nul_reg        <= nul_next;
            end

            // hold the verdict until the downstream takes it
            if (accept_in && s_tlast)
            begin
                out_valid_reg <= 1'b1;
                verdict_reg   <= verdict_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule : process_stat_record_matcher

`default_nettype wire

// ===== hw/rtl/psrm_checker.sv =====
// Port-level assertions for the process status record matcher, with bind.
`default_nettype none

module psrm_checker
    import psrm_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic [7:0] s_tdata,
    input wire logic       s_tlast,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    // a stalled verdict stays offered
    a_hold_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("verdict dropped while stalled");

    // every last-byte transaction produces a verdict on the next cycle
    a_verdict_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no verdict after last byte");

    // a NUL on the last byte forces the NUL verdict
    a_nul_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast && s_tdata == CHAR_NUL
        |=> m_tdata[1:0] == VERDICT_NUL)
        else $error("NUL byte not reported");

    // only defined verdict codes, padding bits zero
    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:2] == 6'b0 &&
                     (m_tdata[1:0] == VERDICT_MATCH ||
                      m_tdata[1:0] == VERDICT_MISMATCH ||
                      m_tdata[1:0] == VERDICT_NUL))
        else $error("undefined verdict code");

endmodule : psrm_checker

bind process_stat_record_matcher psrm_checker u_psrm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/sv/tb_process_stat_record_matcher.sv =====
// Self-checking testbench for the process status record matcher: directed and random records.

module tb_process_stat_record_matcher;
    import psrm_pkg::*;

    localparam int          CYCLE_LIMIT   = 500000;
    localparam int          SKIPPED_TOTAL = TICKS_FIELD - FIRST_SKIP_FIELD;
    localparam logic [63:0] TICKS_MAX     = '1;
    localparam logic [31:0] ID_MAX        = '1;

    // Parse position before and after the last close paren, tracked by the predictor
    typedef enum logic [1:0] {HEAD_ID, HEAD_OPEN, HEAD_BODY, HEAD_FAIL} head_state_t;
    typedef enum logic [2:0] {
        TAIL_IDLE, TAIL_SP1, TAIL_STATE, TAIL_SP2,
        TAIL_PARENT, TAIL_SKIP, TAIL_TICKS, TAIL_DONE
    } tail_state_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [7:0]                 s_tdata   = '0;   // [7:0] text_byte
    logic                       s_tlast   = 1'b0; // last_byte
    logic                       m_tvalid;
    logic                       m_tready  = 1'b1;
    logic [7:0]                 m_tdata;          // [1:0] verdict, [7:2] zero
    logic                       cfg_we    = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;

    // Predictor state and its copy of the configuration registers
    head_state_t head;
    tail_state_t tail;
    logic [63:0] num_value;
    logic        num_ovf;
    logic        has_digit;
    logic        tail_ok;
    logic        saw_nul;
    int          skip_count;
    logic [31:0] cfg_child  = '0;
    logic [31:0] cfg_parent = '0;
    logic [63:0] cfg_ticks  = '0;

    // Verdicts predicted but not yet seen on the master side, oldest first
    logic [1:0]  pending_verdicts[$];
    // Record under construction, sent byte by byte
    logic [7:0]  rec[$];

    bit          idle_enabled = 1'b1;
    int          errors;
    int          cycle_count;
    int          ready_hold;
    int          bytes_sent;
    int          records_sent;
    int          verdicts_checked;
    int          match_count;
    int          mismatch_count;
    int          nul_count;
    logic [1:0]  oldest;

    process_stat_record_matcher dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Verdict predictor
    // ------------------------------------------------------------------

    function automatic void clear_parse();
        head       = HEAD_ID;
        tail       = TAIL_IDLE;
        num_value  = '0;
        num_ovf    = 1'b0;
        has_digit  = 1'b0;
        skip_count = 0;
        tail_ok    = 1'b0;
        saw_nul    = 1'b0;
    endfunction

    function automatic void start_number();
        num_value = '0;
        num_ovf   = 1'b0;
        has_digit = 1'b0;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    // Shift in one decimal digit; latch overflow once the value leaves 64 bits
    function automatic void take_digit_char(input logic [7:0] c);
        logic [63:0] d;
        d = 64'(c) - 64'(CHAR_ZERO);
        has_digit = 1'b1;
        if (!num_ovf)
        begin
            if (num_value > (TICKS_MAX - d) / 64'd10)
                num_ovf = 1'b1;
            else
                num_value = num_value * 64'd10 + d;
        end
    endfunction

    // A decimal closes well when it has digits, fits, equals the register and ends in a space
    function automatic bit num_closes(input logic [7:0] c, input logic [63:0] want);
        return has_digit && !num_ovf && num_value == want && c == CHAR_SPACE;
    endfunction

    function automatic void step_tail(input logic [7:0] c);
        case (tail)
            TAIL_SP1:
                tail = (c == CHAR_SPACE) ? TAIL_STATE : TAIL_DONE;
            TAIL_STATE:
                tail = (c != CHAR_SPACE) ? TAIL_SP2 : TAIL_DONE;
            TAIL_SP2:
                if (c == CHAR_SPACE)
                begin
                    tail = TAIL_PARENT;
                    start_number();
                end
                else
                    tail = TAIL_DONE;
            TAIL_PARENT:
                if (is_digit(c))
                    take_digit_char(c);
                else if (num_closes(c, {32'd0, cfg_parent}))
                begin
                    tail       = TAIL_SKIP;
                    skip_count = 0;
                    has_digit  = 1'b0;
                end
                else
                    tail = TAIL_DONE;
            TAIL_SKIP:
                if (c != CHAR_SPACE)
                    has_digit = 1'b1;
                else if (!has_digit)
                    tail = TAIL_DONE;
                else
                begin
                    skip_count++;
                    has_digit = 1'b0;
                    if (skip_count >= SKIPPED_TOTAL)
                    begin
                        tail = TAIL_TICKS;
                        start_number();
                    end
                end
            TAIL_TICKS:
                if (is_digit(c))
                    take_digit_char(c);
                else
                begin
                    tail_ok = num_closes(c, cfg_ticks);
                    tail    = TAIL_DONE;
                end
            default:
                ;
        endcase
    endfunction

    // Advance the parse by one accepted byte; queue the verdict on the last byte
    function automatic void advance_record_parse(input logic [7:0] c, input logic is_last);
        if (c == CHAR_NUL)
            saw_nul = 1'b1;
        case (head)
            HEAD_ID:
                if (is_digit(c))
                    take_digit_char(c);
                else
                    head = num_closes(c, {32'd0, cfg_child}) ? HEAD_OPEN : HEAD_FAIL;
            HEAD_OPEN:
                head = (c == CHAR_OPEN) ? HEAD_BODY : HEAD_FAIL;
            HEAD_BODY:
                if (c == CHAR_CLOSE)
                begin
                    // every close paren restarts the tail checks
                    tail    = TAIL_SP1;
                    tail_ok = 1'b0;
                end
                else
                    step_tail(c);
            default:
                ;
        endcase
        if (is_last)
        begin
            if (saw_nul)
                pending_verdicts.push_back(VERDICT_NUL);
            else if (head == HEAD_BODY && tail_ok)
                pending_verdicts.push_back(VERDICT_MATCH);
            else
                pending_verdicts.push_back(VERDICT_MISMATCH);
            clear_parse();
        end
    endfunction

    // ------------------------------------------------------------------
    // Master side: random stall bursts and the verdict check
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (!idle_enabled)
            m_tready <= 1'b1;
        else if (ready_hold > 0)
        begin
            ready_hold--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            // start a stall burst of random length
            ready_hold = $urandom_range(0, 13);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Compare each verdict transaction with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected verdict, expected none, actual %0d",
                         $time, m_tdata[1:0]);
                errors++;
            end
            else
            begin
                oldest = pending_verdicts.pop_front();
                verdicts_checked++;
                if (m_tdata !== {6'd0, oldest})
                begin
                    $display("%0t: verdict mismatch, expected %0d, actual tdata %h",
                             $time, oldest, m_tdata);
                    errors++;
                end
                case (oldest)
                    VERDICT_MATCH:    match_count++;
                    VERDICT_MISMATCH: mismatch_count++;
                    default:          nul_count++;
                endcase
            end
        end
    end

    // Watchdog: end the run once the total cycle count passes CYCLE_LIMIT
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d verdicts outstanding",
                     $time, cycle_count, pending_verdicts.size());
            $display("tb_process_stat_record_matcher failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Slave side and configuration drivers (called at a rising edge)
    // ------------------------------------------------------------------

    // Present one byte, hold it until the transaction completes, then predict
    task automatic send_byte(input logic [7:0] c, input logic is_last);
        if (idle_enabled && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        advance_record_parse(c, is_last);
        bytes_sent++;
    endtask

    task automatic send_record();
        for (int i = 0; i < rec.size(); i++)
            send_byte(rec[i], i == rec.size() - 1);
        rec.delete();
        records_sent++;
    endtask

    // Drop valid and hold until every predicted verdict has come back
    task automatic wait_verdicts_drained();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        // let the output register settle before touching the registers
        repeat (4) @(posedge clk);
    endtask

    // Leaves the write enable high; the caller drops it after its last write
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] index,
                             input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        case (index)
            REG_CHILD_ID:    cfg_child  = data[31:0];
            REG_PARENT_ID:   cfg_parent = data[31:0];
            REG_START_TICKS: cfg_ticks  = data;
            default:         ;
        endcase
    endtask

    // Junk in the upper half of the id writes must be dropped by the block
    task automatic set_config(input logic [31:0] child, input logic [31:0] parent,
                              input logic [63:0] ticks);
        wait_verdicts_drained();
        write_reg(REG_CHILD_ID, {32'($urandom), child});
        write_reg(REG_PARENT_ID, {32'($urandom), parent});
        write_reg(REG_START_TICKS, ticks);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Record construction
    // ------------------------------------------------------------------

    task automatic put_char(input logic [7:0] c);
        rec.push_back(c);
    endtask

    task automatic put_text(input string text);
        for (int i = 0; i < text.len(); i++)
            rec.push_back(8'(text[i]));
    endtask

    task automatic put_dec(input logic [63:0] v, input int zeros);
        logic [7:0] digits[$];
        repeat (zeros) rec.push_back(CHAR_ZERO);
        do
        begin
            digits.push_front(CHAR_ZERO + 8'(v % 64'd10));
            v = v / 64'd10;
        end
        while (v != 0);
        foreach (digits[i])
            rec.push_back(digits[i]);
    endtask

    function automatic int lead_zeros();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // Any byte that may sit inside a field: no space, no close paren, no NUL
    function automatic logic [7:0] field_char();
        logic [7:0] c;
        if ($urandom_range(0, 1) == 0)
            return CHAR_ZERO + 8'($urandom_range(0, 9));
        do
        begin
            c = 8'($urandom_range(1, 255));
        end
        while (c == CHAR_SPACE || c == CHAR_CLOSE);
        return c;
    endfunction

    task automatic put_fields(input int n);
        repeat (n)
        begin
            repeat ($urandom_range(1, 2)) put_char(field_char());
            put_char(CHAR_SPACE);
        end
    endtask

    // Well-formed record; the command name may hold spaces and close parens
    task automatic build_record(input logic [63:0] child, input logic [63:0] parent,
                                input logic [63:0] ticks);
        int trailing;
        rec.delete();
        put_dec(child, lead_zeros());
        put_char(CHAR_SPACE);
        put_char(CHAR_OPEN);
        repeat ($urandom_range(0, 12)) put_char(8'($urandom_range(1, 255)));
        put_char(CHAR_CLOSE);
        put_char(CHAR_SPACE);
        put_char(field_char());
        put_char(CHAR_SPACE);
        put_dec(parent, lead_zeros());
        put_char(CHAR_SPACE);
        put_fields(SKIPPED_TOTAL);
        put_dec(ticks, lead_zeros());
        put_char(CHAR_SPACE);
        trailing = $urandom_range(0, 4);
        put_fields(trailing);
        if (trailing > 0 && $urandom_range(0, 1) == 0)
            void'(rec.pop_back());
    endtask

    // Break a record in one random place
    task automatic mutate_record();
        int pos;
        int cut;
        pos = $urandom_range(0, rec.size() - 1);
        case ($urandom_range(0, 5))
            0: rec[pos] = 8'($urandom_range(0, 255));
            1:
            begin
                cut = $urandom_range(1, rec.size() - 1);
                while (rec.size() > cut)
                    void'(rec.pop_back());
            end
            2: rec.insert(pos, CHAR_NUL);
            3: rec.insert(pos, CHAR_CLOSE);
            4: rec.delete(pos);
            default: rec.insert(pos, CHAR_SPACE);
        endcase
    endtask

    function automatic logic [31:0] pick_id();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return ID_MAX;
            2:       return 32'($urandom_range(0, 99999));
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] pick_ticks();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return TICKS_MAX;
            2:       return 64'($urandom_range(0, 9999999));
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    // Mostly well-formed records with random content, the rest broken or noise
    task automatic send_random_record();
        int kind;
        kind = $urandom_range(0, 19);
        if (kind < 11)
            build_record(cfg_child, cfg_parent, cfg_ticks);
        else if (kind < 16)
        begin
            build_record(cfg_child, cfg_parent, cfg_ticks);
            mutate_record();
        end
        else if (kind == 16)
            build_record(64'(cfg_child) + 64'd1, cfg_parent, cfg_ticks);
        else if (kind == 17)
            build_record(cfg_child, 64'(cfg_parent) + 64'd1, cfg_ticks);
        else if (kind == 18)
            build_record(cfg_child, cfg_parent, cfg_ticks + 64'd1);
        else
        begin
            rec.delete();
            repeat ($urandom_range(1, 30)) put_char(8'($urandom_range(0, 255)));
        end
        send_record();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers come out of reset at zero
    task automatic test_reset_defaults();
        build_record(0, 0, 0);
        send_record();
        build_record(1, 0, 0);
        send_record();
    endtask

    // One-byte records are judged like any other
    task automatic test_single_byte_records();
        put_text("7");
        send_record();
        put_char(CHAR_NUL);
        send_record();
        put_char(CHAR_CLOSE);
        send_record();
        put_char(CHAR_SPACE);
        send_record();
    endtask

    // A NUL anywhere decides the verdict, even after a prefix failure
    task automatic test_nul_bytes();
        set_config(31, 7, 500);
        build_record(31, 7, 500);
        rec.insert($urandom_range(1, rec.size() - 1), CHAR_NUL);
        send_record();
        put_text("abc");
        put_char(CHAR_NUL);
        send_record();
        build_record(31, 7, 500);
        put_char(CHAR_NUL);
        send_record();
    endtask

    // The last close paren governs the tail checks
    task automatic test_close_paren_rules();
        set_config(12, 1, 99);
        put_text("12 (a) b) c) R 1 ");
        put_fields(SKIPPED_TOTAL);
        put_text("99 tail");
        send_record();
        build_record(12, 1, 99);
        put_char(CHAR_CLOSE);
        send_record();
        put_text("12 (x) S 1 ");
        put_fields(5);
        put_text(") ");
        put_fields(SKIPPED_TOTAL - 5);
        put_text("99 ");
        send_record();
        put_text("12 (init)");
        send_record();
        put_text("12 (abc");
        send_record();
    endtask

    // Register extremes, 64-bit overflow, leading zeros and empty decimals
    task automatic test_number_limits();
        set_config(ID_MAX, ID_MAX, TICKS_MAX);
        build_record(ID_MAX, ID_MAX, TICKS_MAX);
        send_record();
        put_text("4294967295 (p) S 4294967295 ");
        put_fields(SKIPPED_TOTAL);
        put_dec(TICKS_MAX, 0);
        rec[rec.size() - 1] = rec[rec.size() - 1] + 8'd1;
        put_char(CHAR_SPACE);
        send_record();
        build_record(64'h1_0000_0000, ID_MAX, TICKS_MAX);
        send_record();
        put_text("4294967295 (p) S 123456789012345678901234 ");
        put_fields(SKIPPED_TOTAL);
        put_text("18446744073709551615 ");
        send_record();
        set_config(0, 0, 0);
        put_text("000 (z) S 0000 ");
        put_fields(SKIPPED_TOTAL);
        put_text("00000000000000000000000 ");
        send_record();
        put_text(" (z) S 0 ");
        put_fields(SKIPPED_TOTAL);
        put_text("0 ");
        send_record();
        put_text("0 (z) S 0 ");
        put_fields(SKIPPED_TOTAL);
        put_text(" ");
        send_record();
    endtask

    // Each separator and field count that the layout requires
    task automatic test_layout_errors();
        set_config(31, 7, 500);
        put_text("31 x) S 7 ");
        put_fields(SKIPPED_TOTAL);
        put_text("500 ");
        send_record();
        put_text("31(a) S 7 ");
        put_fields(SKIPPED_TOTAL);
        put_text("500 ");
        send_record();
        put_text("31 (a)   7 ");
        put_fields(SKIPPED_TOTAL);
        put_text("500 ");
        send_record();
        put_text("31 (a) S 7 ");
        put_fields(3);
        put_char(CHAR_SPACE);
        put_fields(SKIPPED_TOTAL - 3);
        put_text("500 ");
        send_record();
        put_text("31 (a) S 7 ");
        put_fields(SKIPPED_TOTAL);
        put_text("500");
        send_record();
        put_text("31 (a) S 7 ");
        put_fields(SKIPPED_TOTAL);
        put_text("501 ");
        send_record();
        put_text("31 (a) S 7 ");
        put_fields(SKIPPED_TOTAL - 1);
        put_text("500 ");
        send_record();
    endtask

    // Random phases, each under a fresh register setting
    task automatic test_random_records();
        repeat (2)
        begin
            set_config(pick_id(), pick_id(), pick_ticks());
            repeat (3) send_random_record();
        end
    endtask

    // Hold the sender until the pipeline is empty, then restart
    task automatic test_drained_restart();
        send_random_record();
        wait_verdicts_drained();
        send_random_record();
    endtask

    // Back-to-back traffic with no stalls on either side
    task automatic test_quiet_tail();
        idle_enabled = 1'b0;
        repeat (3) send_random_record();
    endtask

    initial
    begin
        clear_parse();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_single_byte_records();
        test_nul_bytes();
        test_close_paren_rules();
        test_number_limits();
        test_layout_errors();
        test_random_records();
        test_drained_restart();
        test_quiet_tail();

        wait_verdicts_drained();
        $display("run covered %0d records in %0d bytes, %0d verdicts checked",
                 records_sent, bytes_sent, verdicts_checked);
        $display("verdicts: %0d match, %0d mismatch, %0d nul; %0d errors",
                 match_count, mismatch_count, nul_count, errors);
        if (errors == 0 && pending_verdicts.size() == 0)
            $display("tb_process_stat_record_matcher passed");
        else
            $display("tb_process_stat_record_matcher failed");
        $finish;
    end

endmodule
